// ----- rtl/core/hsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsu_pkg
// Shared types and constants for the header symbol unpacker.
// ----------------------------------------------------------------------------
package hsu_pkg;

  // symbol width codes from header bits 1..0
  localparam logic [1:0] ModeTwoBit   = 2'd0;
  localparam logic [1:0] ModeFourBit  = 2'd1;
  localparam logic [1:0] ModeByte     = 2'd2;
  localparam logic [1:0] ModeWord     = 2'd3;

  // result kinds
  localparam logic KindHeader = 1'b0;
  localparam logic KindSymbol = 1'b1;

  // job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic        result_kind;
    logic [31:0] symbol_value;
    logic [1:0]  width_mode;
    logic [4:0]  tree_depth;
    logic        last_of_run;
  } out_beat_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        is_header;
    logic [1:0]  mode;
    logic [4:0]  depth;
    logic [31:0] data;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/core/hsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsu_front
// Accepts bytes, tracks header and word state, pushes jobs to the queue.
// ----------------------------------------------------------------------------
module hsu_front import hsu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  in_beat_t      in_data_i,
  output logic          in_stall_o,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output job_t          job_o
);

  logic        expect_q, expect_d;
  logic [1:0]  mode_q, mode_d;
  logic [4:0]  depth_q, depth_d;
  logic [23:0] accum_q, accum_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        in_fire;
  logic [7:0]  byte_w;
  logic        eob_w;

  assign in_stall_o = q_status_i.full;
  assign in_fire    = in_valid_i && !q_status_i.full;
  assign byte_w     = in_data_i.data_byte;
  assign eob_w      = in_data_i.end_of_buffer;

  // a job is pushed unless the byte only extends a partial word
  assign push_o = in_fire && (expect_q || (mode_q != ModeWord) || (cnt_q == 2'd3));

  // job contents
  always_comb begin
    job_o.is_header = expect_q;
    job_o.mode      = expect_q ? byte_w[1:0] : mode_q;
    job_o.depth     = expect_q ? byte_w[6:2] : depth_q;
    if (expect_q) begin
      job_o.data = 32'd0;
    end else if (mode_q == ModeWord) begin
      job_o.data = {byte_w, accum_q};
    end else begin
      job_o.data = {24'd0, byte_w};
    end
  end

  // next state
  always_comb begin
    expect_d = expect_q;
    mode_d   = mode_q;
    depth_d  = depth_q;
    accum_d  = accum_q;
    cnt_d    = cnt_q;
    if (in_fire) begin
      if (expect_q) begin
        mode_d   = byte_w[1:0];
        depth_d  = byte_w[6:2];
        accum_d  = 24'd0;
        cnt_d    = 2'd0;
        expect_d = eob_w;
      end else begin
        if (mode_q == ModeWord) begin
          unique case (cnt_q)
            2'd0: accum_d[7:0]   = byte_w;
            2'd1: accum_d[15:8]  = byte_w;
            2'd2: accum_d[23:16] = byte_w;
            default: accum_d     = 24'd0;
          endcase
          cnt_d = cnt_q + 2'd1;
        end
        if (eob_w) begin
          expect_d = 1'b1;
          accum_d  = 24'd0;
          cnt_d    = 2'd0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      mode_q   <= 2'd0;
      depth_q  <= 5'd0;
      accum_q  <= 24'd0;
      cnt_q    <= 2'd0;
    end else begin
      expect_q <= expect_d;
      mode_q   <= mode_d;
      depth_q  <= depth_d;
      accum_q  <= accum_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/hsu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsu_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module hsu_queue import hsu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          job_i,
  input  logic          pop_i,
  output job_t          head_o,
  output queue_status_t status_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/hsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsu_back
// Expands each job into its results, one beat per cycle while out_stall_i is
// low, into the output register.
// ----------------------------------------------------------------------------
module hsu_back import hsu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  job_t          job_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output out_beat_t     out_data_o,
  input  logic          out_stall_i
);

  logic       out_valid_q, out_valid_d;
  out_beat_t  out_data_q;
  out_beat_t  res;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       last;

  assign load = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  // select the current result of the head job
  always_comb begin
    res.result_kind = job_i.is_header ? KindHeader : KindSymbol;
    res.width_mode  = job_i.mode;
    res.tree_depth  = job_i.depth;
    res.symbol_value = job_i.data;
    last            = 1'b1;
    if (!job_i.is_header) begin
      unique case (job_i.mode)
        ModeTwoBit: begin
          unique case (idx_q)
            2'd0: res.symbol_value = {30'd0, job_i.data[1:0]};
            2'd1: res.symbol_value = {30'd0, job_i.data[3:2]};
            2'd2: res.symbol_value = {30'd0, job_i.data[5:4]};
            default: res.symbol_value = {30'd0, job_i.data[7:6]};
          endcase
          last = (idx_q == 2'd3);
        end
        ModeFourBit: begin
          res.symbol_value = idx_q[0] ? {28'd0, job_i.data[7:4]}
                                      : {28'd0, job_i.data[3:0]};
          last = idx_q[0];
        end
        default: begin
          res.symbol_value = job_i.data;
          last = 1'b1;
        end
      endcase
    end
    res.last_of_run = last;
  end

  assign pop_o = load && last;

  // result index and output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/header_symbol_unpacker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_symbol_unpacker_core
// Byte stream unpacker: header byte per buffer, then 2/4/8/32-bit symbols.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the four-entry job queue has room.
// The result register gives one beat per cycle while out_stall_i is low, so
// a byte in two-bit mode gives four result beats, a four-bit byte two, a
// header or eight-bit byte one; in 32-bit mode four bytes give one word.
// Sustained input rate is therefore set by the result register.
// ----------------------------------------------------------------------------
module header_symbol_unpacker_core import hsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_beat_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_beat_t out_data_o,
  input  logic      out_stall_i
);

  queue_status_t q_status;
  logic          push, pop;
  job_t          push_job, head_job;

  // classify incoming bytes
  hsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  // job queue
  hsu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (q_status)
  );

  // expand jobs to results
  hsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("push into full job queue");

  // back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("pop from empty job queue");

  // a header result carries zero value and ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.result_kind == KindHeader)) |->
      ((out_data_o.symbol_value == 32'd0) && out_data_o.last_of_run))
    else $error("malformed header result");

  // a pop always comes with a new beat loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("job popped without a result");
`endif

endmodule
